### hw/rtl/hrhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the http request header parser
// keyword tables, byte classes, error codes and the one-hot parse phases
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int NUM_METHODS = 9;
    localparam int KW_MAX_LEN  = 7;

    // special bytes
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [3:0] METHOD_NONE = 4'd0;

    // method keywords, index order gives method code minus one
    localparam logic [7:0] KW_TEXT [NUM_METHODS][KW_MAX_LEN] = '{
        '{"G", "E", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"P", "O", "S", "T", CH_NUL, CH_NUL, CH_NUL},
        '{"H", "E", "A", "D", CH_NUL, CH_NUL, CH_NUL},
        '{"P", "U", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"O", "P", "T", "I", "O", "N", "S"},
        '{"D", "E", "L", "E", "T", "E", CH_NUL},
        '{"T", "R", "A", "C", "E", CH_NUL, CH_NUL},
        '{"C", "O", "N", "N", "E", "C", "T"},
        '{"P", "A", "T", "C", "H", CH_NUL, CH_NUL}
    };

    localparam logic [2:0] KW_LEN [NUM_METHODS] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd7, 3'd6, 3'd5, 3'd7, 3'd5
    };

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_GAP     = 3'd1,
        KIND_URI     = 3'd2,
        KIND_VERSION = 3'd3,
        KIND_KEY     = 3'd4,
        KIND_VALUE   = 3'd5,
        KIND_DELIM   = 3'd6,
        KIND_BODY    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_EMPTY   = 2'd1,
        ERR_UNKNOWN = 2'd2
    } err_t;

    typedef enum logic [7:0] {
        PH_METHOD  = 8'b0000_0001,
        PH_GAP     = 8'b0000_0010,
        PH_URI     = 8'b0000_0100,
        PH_VERSION = 8'b0000_1000,
        PH_KEY     = 8'b0001_0000,
        PH_VALUE   = 8'b0010_0000,
        PH_DISCARD = 8'b0100_0000,
        PH_BODY    = 8'b1000_0000
    } phase_t;

endpackage
`default_nettype wire

### hw/rtl/http_request_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_header_parser: byte-wise http/1.1 request header classifier
// tags each request byte with its token class, method, error and header index
// ----------------------------------------------------------------------------
// The parser takes one request byte per transfer on the s_ side and returns
// one tagged byte per transfer on the m_ side. It sustains one byte per clock
// while not stalled: a byte is captured in an input register, classified by a
// single layer of logic against the parse state (method keyword mask, phase,
// previous byte, header count) and written to the result register, from which
// it leaves on the m_ side. The method is found with a nine-bit candidate mask
// narrowed one keyword position per byte. The byte after the keyword is a gap,
// the uri ends at a space, the version at cr lf, each header key at ": " and
// each value at cr lf; after the blank line every byte is body. A header line
// without ": " enters the discard phase at its cr and goes back to key parsing
// after its cr lf. An empty message (first byte zero) or an unknown method
// marks every further byte as delimiter with the error code held. s_tlast ends
// the message and all parse state returns to its reset value after that byte.
// The pipeline stalls only while m_tready is low and the result is held.
// ----------------------------------------------------------------------------
module http_request_header_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] byte_value, [11:8] method_code,
                                        // [13:12] error_code, [21:14] header_number,
                                        // [22] headers_done, [23] zero
    output logic [2:0]       m_tuser,   // [2:0] byte_kind
    output logic             m_tlast    // message_end
);
    import hrhp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    kind_t       out_kind_reg;
    logic [3:0]  out_method_reg;
    err_t        out_err_reg;
    logic [7:0]  out_hnum_reg;
    logic        out_done_reg;
    logic        out_last_reg;

    // parse state
    phase_t                 phase_reg,      phase_next;
    logic [NUM_METHODS-1:0] cand_reg,       cand_next;
    logic [2:0]             match_pos_reg,  match_pos_next;
    logic [3:0]             method_reg,     method_next;
    logic [7:0]             prev_byte_reg,  prev_byte_next;
    logic                   line_start_reg, line_start_next;
    logic [7:0]             hdr_cnt_reg,    hdr_cnt_next;
    err_t                   err_reg,        err_next;

    // per-byte results
    kind_t      kind;
    err_t       err_out;
    logic [3:0] method_out;
    logic       done_out;

    logic                   advance;
    logic                   step;
    logic                   cr_lf;
    logic [2:0]             pos;
    logic [NUM_METHODS-1:0] keep;

    // the result register moves when it is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    assign cr_lf = (in_data_reg == CH_LF) && (prev_byte_reg == CH_CR);

    // keyword position wraps at the longest keyword
    assign pos = (match_pos_reg == 3'(KW_MAX_LEN)) ? 3'd0 : match_pos_reg;

    // candidates that still match at this position
    always_comb begin
        for (int c = 0; c < NUM_METHODS; c++) begin
            keep[c] = cand_reg[c] && (KW_LEN[c] > pos) && (KW_TEXT[c][pos] == in_data_reg);
        end
    end

    // classification and next parse state
    always_comb begin
        kind            = KIND_DELIM;
        phase_next      = phase_reg;
        cand_next       = cand_reg;
        match_pos_next  = match_pos_reg;
        method_next     = method_reg;
        line_start_next = line_start_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        err_next        = err_reg;
        prev_byte_next  = in_data_reg;

        if (err_reg == ERR_NONE) begin
            case (phase_reg)
                PH_METHOD: begin
                    if (match_pos_reg == 3'd0 && in_data_reg == CH_NUL) begin
                        err_next = ERR_EMPTY;
                    end else if (keep == '0) begin
                        err_next = ERR_UNKNOWN;
                    end else begin
                        kind           = KIND_METHOD;
                        cand_next      = keep;
                        match_pos_next = pos + 3'd1;
                        for (int c = 0; c < NUM_METHODS; c++) begin
                            if (keep[c] && ({1'b0, KW_LEN[c]} == {1'b0, pos} + 4'd1)) begin
                                method_next = 4'(c + 1);
                                phase_next  = PH_GAP;
                            end
                        end
                    end
                end
                PH_GAP: begin
                    kind            = KIND_GAP;
                    phase_next      = PH_URI;
                    line_start_next = 1'b1;
                end
                PH_URI: begin
                    // zero as first uri byte means no uri at all
                    if (line_start_reg && in_data_reg == CH_NUL) begin
                        kind       = KIND_VERSION;
                        phase_next = PH_VERSION;
                    end else if (in_data_reg == CH_SPACE) begin
                        phase_next = PH_VERSION;
                    end else begin
                        kind = KIND_URI;
                    end
                    line_start_next = 1'b0;
                end
                PH_VERSION: begin
                    if (in_data_reg == CH_CR) begin
                        kind = KIND_DELIM;
                    end else if (cr_lf) begin
                        phase_next      = PH_KEY;
                        line_start_next = 1'b1;
                    end else begin
                        kind = KIND_VERSION;
                    end
                end
                PH_KEY: begin
                    if (in_data_reg == CH_CR) begin
                        // cr inside a key line with no ": " discards the line
                        if (!line_start_reg) begin
                            phase_next = PH_DISCARD;
                        end
                    end else if (cr_lf && line_start_reg) begin
                        phase_next = PH_BODY;
                    end else if (in_data_reg == CH_COLON) begin
                        line_start_next = 1'b0;
                    end else if (in_data_reg == CH_SPACE && prev_byte_reg == CH_COLON) begin
                        phase_next = PH_VALUE;
                    end else begin
                        kind            = KIND_KEY;
                        line_start_next = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (in_data_reg == CH_CR) begin
                        kind = KIND_DELIM;
                    end else if (cr_lf) begin
                        if (hdr_cnt_reg != 8'hff) begin
                            hdr_cnt_next = hdr_cnt_reg + 8'd1;
                        end
                        phase_next      = PH_KEY;
                        line_start_next = 1'b1;
                    end else begin
                        kind = KIND_VALUE;
                    end
                end
                PH_DISCARD: begin
                    if (cr_lf) begin
                        if (hdr_cnt_reg != 8'hff) begin
                            hdr_cnt_next = hdr_cnt_reg + 8'd1;
                        end
                        phase_next      = PH_KEY;
                        line_start_next = 1'b1;
                    end
                end
                PH_BODY: begin
                    kind = KIND_BODY;
                end
                default: begin
                    kind = KIND_DELIM;
                end
            endcase
        end

        // status seen by this byte is the state after it
        method_out = method_next;
        err_out    = err_next;
        done_out   = (err_next == ERR_NONE) && (phase_next == PH_BODY);

        // end of message: back to the reset state
        if (in_last_reg) begin
            phase_next      = PH_METHOD;
            cand_next       = '1;
            match_pos_next  = 3'd0;
            method_next     = METHOD_NONE;
            prev_byte_next  = 8'd0;
            line_start_next = 1'b0;
            hdr_cnt_next    = 8'd0;
            err_next        = ERR_NONE;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // parse state, updated once per classified byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_METHOD;
            cand_reg       <= '1;
            match_pos_reg  <= 3'd0;
            method_reg     <= METHOD_NONE;
            prev_byte_reg  <= 8'd0;
            line_start_reg <= 1'b0;
            hdr_cnt_reg    <= 8'd0;
            err_reg        <= ERR_NONE;
        end else if (step) begin
            phase_reg      <= phase_next;
            cand_reg       <= cand_next;
            match_pos_reg  <= match_pos_next;
            method_reg     <= method_next;
            prev_byte_reg  <= prev_byte_next;
            line_start_reg <= line_start_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            err_reg        <= err_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_byte_reg   <= in_data_reg;
            out_kind_reg   <= kind;
            out_method_reg <= method_out;
            out_err_reg    <= err_out;
            out_hnum_reg   <= hdr_cnt_reg;  // header index before this byte
            out_done_reg   <= done_out;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_done_reg, out_hnum_reg, out_err_reg,
                       out_method_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
